// ===== src/uv_sphere_vertex_and_index_generator_top_macros.svh =====
// ----------------------------------------------------------------------------
// UV sphere generator assertion macros
// Concurrent checks clocked on clk and quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_AND_INDEX_GENERATOR_TOP_MACROS_SVH
`define UV_SPHERE_VERTEX_AND_INDEX_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define UVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uv sphere check failed");

// next-cycle implication
`define UVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uv sphere check failed");

`endif

// ===== src/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, register codes, sine table and arithmetic helpers of the
// UV sphere vertex and index generator.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

  // grid index width and sine table depth (power of two)
  localparam int IDX_W      = 8;
  localparam int SINE_DEPTH = 1024;
  localparam int SIN_BITS   = $clog2(SINE_DEPTH);
  localparam int QTR_BITS   = SIN_BITS - 2;
  localparam int QDEPTH     = SINE_DEPTH / 4;
  localparam int CMP_W      = ((IDX_W > 8) ? IDX_W : 8) + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [IDX_W+15:0] wprod_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECTOR_COUNT      = 3'd0,
    REG_STACK_COUNT       = 3'd1,
    REG_RADIUS            = 3'd2,
    REG_SECTOR_PHASE_STEP = 3'd3,
    REG_STACK_PHASE_STEP  = 3'd4,
    REG_TEX_S_STEP        = 3'd5,
    REG_TEX_T_STEP        = 3'd6
  } cfg_reg_t;

  localparam logic [7:0]  SECTOR_COUNT_RST      = 8'd36;
  localparam logic [7:0]  STACK_COUNT_RST       = 8'd18;
  localparam logic [15:0] RADIUS_RST            = 16'd256;
  localparam logic [15:0] SECTOR_PHASE_STEP_RST = 16'd1820;
  localparam logic [15:0] STACK_PHASE_STEP_RST  = 16'd1820;
  localparam logic [15:0] TEX_S_STEP_RST        = 16'd1138;
  localparam logic [15:0] TEX_T_STEP_RST        = 16'd2276;

  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  // sine and cosine of both angles, Q1.15
  typedef struct packed {
    logic signed [15:0] cu;
    logic signed [15:0] su;
    logic signed [15:0] cv;
    logic signed [15:0] sv;
  } trig_t;

  // fields that ride alongside the trig datapath
  typedef struct packed {
    logic [15:0] tex_s;
    logic [15:0] tex_t;
    logic [15:0] k1;
    logic [15:0] k2;
    logic        upper;
    logic        lower;
  } side_t;

  // quarter-wave sine magnitudes, Q1.15, built with a Q30 Taylor series
  function automatic logic [QDEPTH-1:0][15:0] build_qsin();
    logic [QDEPTH-1:0][15:0] t;
    logic [63:0] a, x, x2, sum, term, s;
    int k;
    for (k = 0; k < QDEPTH; k++) begin
      a    = 64'(k) << (30 - QTR_BITS);
      x    = (a * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      sum  = x;
      term = ((x * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - term;
      if (sum > Q30_ONE) sum = Q30_ONE;
      s = (sum + 64'd16384) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      t[k] = s[15:0];
    end
    return t;
  endfunction

  localparam logic [QDEPTH-1:0][15:0] SIN_Q = build_qsin();

  // sine of a 16-bit phase through the quarter-wave table
  function automatic logic signed [15:0] sin_of(input logic [15:0] ph);
    logic [SIN_BITS-1:0] idx;
    logic [1:0]          quad;
    logic [QTR_BITS:0]   r;
    logic [15:0]         mag;
    idx  = ph[15 -: SIN_BITS];
    quad = idx[SIN_BITS-1 -: 2];
    r    = {1'b0, idx[QTR_BITS-1:0]};
    if (quad[0]) r = (QTR_BITS + 1)'(QDEPTH) - r;
    // the quarter point itself lies past the table: full scale
    mag  = r[QTR_BITS] ? 16'd32767 : SIN_Q[r[QTR_BITS-1:0]];
    return quad[1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [15:0] cos_of(input logic [15:0] ph);
    return sin_of(ph + QUARTER_TURN);
  endfunction

  // round half up by 2^sh, then saturate to signed 16 bits
  function automatic logic [15:0] rnd_sat(input logic signed [49:0] p, input int sh);
    logic signed [49:0] q;
    logic signed [49:0] r;
    q = p + (50'sd1 <<< (sh - 1));
    r = q >>> sh;
    if (r > 50'sd32767) return 16'h7FFF;
    if (r < -50'sd32768) return 16'h8000;
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/uvs_if.sv =====
// ----------------------------------------------------------------------------
// uvs_if
// Valid/ready channels for grid points in and vertex records out.
// ----------------------------------------------------------------------------
`default_nettype none

interface uvs_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] stack_index;
  logic [7:0] sector_index;

  modport source (output valid, stack_index, sector_index, input ready);
  modport sink   (input valid, stack_index, sector_index, output ready);
  modport mon    (input valid, ready, stack_index, sector_index);
endinterface

interface uvs_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pos_z;
  logic [15:0] norm_x;
  logic [15:0] norm_y;
  logic [15:0] norm_z;
  logic [15:0] tex_s;
  logic [15:0] tex_t;
  logic [15:0] row_base;
  logic [15:0] next_row_base;
  logic        upper_tri_valid;
  logic        lower_tri_valid;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s,
                  tex_t, row_base, next_row_base, upper_tri_valid, lower_tri_valid,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s,
                  tex_t, row_base, next_row_base, upper_tri_valid, lower_tri_valid,
                  output ready);
  modport mon    (input valid, ready, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tex_s, tex_t, row_base, next_row_base, upper_tri_valid,
                  lower_tri_valid);
endinterface

`default_nettype wire

// ===== src/uv_sphere_vertex_and_index_generator_top.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_vertex_and_index_generator_top
// Grid point to vertex position, normal, texture coordinates and triangle
// base indices, five-stage pipeline.
// ----------------------------------------------------------------------------
//   channel   dir  handshake      beat
//   vtx_req   in   valid/ready    stack_index, sector_index
//   vtx_rsp   out  valid/ready    position, normal, texture, bases, flags
//   cfg       in   cfg_we         cfg_index, cfg_data (write only)
//
// One beat per clock in and out while vtx_rsp.ready stays high; a result is
// registered through the stages below before it shows on vtx_rsp. Stages:
// phase/index multiply, sine table, trig products, radius products, rounding
// and saturation. Each stage holds its beat while the next one is full and
// held, so empty stages keep filling during a stall.
// rst (synchronous) clears the stage valids and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sphere_vertex_and_index_generator_top (
  input  logic                             clk,
  input  logic                             rst,
  uvs_req_if.sink                          vtx_req,
  uvs_rsp_if.source                        vtx_rsp,
  input  logic                             cfg_we,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uvs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // configuration registers
  logic [7:0]  sector_count;
  logic [7:0]  stack_count;
  logic [15:0] radius;
  logic [15:0] sector_phase_step;
  logic [15:0] stack_phase_step;
  logic [15:0] tex_s_step;
  logic [15:0] tex_t_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count      <= uvs_pkg::SECTOR_COUNT_RST;
      stack_count       <= uvs_pkg::STACK_COUNT_RST;
      radius            <= uvs_pkg::RADIUS_RST;
      sector_phase_step <= uvs_pkg::SECTOR_PHASE_STEP_RST;
      stack_phase_step  <= uvs_pkg::STACK_PHASE_STEP_RST;
      tex_s_step        <= uvs_pkg::TEX_S_STEP_RST;
      tex_t_step        <= uvs_pkg::TEX_T_STEP_RST;
    end else if (cfg_we) begin
      case (uvs_pkg::cfg_reg_t'(cfg_index))
        uvs_pkg::REG_SECTOR_COUNT:      sector_count      <= cfg_data[7:0];
        uvs_pkg::REG_STACK_COUNT:       stack_count       <= cfg_data[7:0];
        uvs_pkg::REG_RADIUS:            radius            <= cfg_data;
        uvs_pkg::REG_SECTOR_PHASE_STEP: sector_phase_step <= cfg_data;
        uvs_pkg::REG_STACK_PHASE_STEP:  stack_phase_step  <= cfg_data;
        uvs_pkg::REG_TEX_S_STEP:        tex_s_step        <= cfg_data;
        uvs_pkg::REG_TEX_T_STEP:        tex_t_step        <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || vtx_rsp.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign vtx_req.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= vtx_req.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // stage 1: phases, texture, bases, triangle flags
  uvs_pkg::idx_t   st, se;
  uvs_pkg::wprod_t pu, pv, pts, ptt, pk;
  logic [8:0]      sc_p1;
  logic            in_mesh, last_stack;
  uvs_pkg::side_t  side_d;
  logic [15:0]     u_d, v_d;

  always_comb begin
    st     = uvs_pkg::idx_t'(vtx_req.stack_index);
    se     = uvs_pkg::idx_t'(vtx_req.sector_index);
    pu     = uvs_pkg::wprod_t'(st) * uvs_pkg::wprod_t'(stack_phase_step);
    pv     = uvs_pkg::wprod_t'(se) * uvs_pkg::wprod_t'(sector_phase_step);
    pts    = uvs_pkg::wprod_t'(se) * uvs_pkg::wprod_t'(tex_s_step);
    ptt    = uvs_pkg::wprod_t'(st) * uvs_pkg::wprod_t'(tex_t_step);
    sc_p1  = {1'b0, sector_count} + 9'd1;
    pk     = uvs_pkg::wprod_t'(st) * uvs_pkg::wprod_t'(sc_p1) + uvs_pkg::wprod_t'(se);
    u_d    = uvs_pkg::QUARTER_TURN - pu[15:0];
    v_d    = pv[15:0];
    in_mesh = (uvs_pkg::cmp_t'(st) < uvs_pkg::cmp_t'(stack_count)) &&
              (uvs_pkg::cmp_t'(se) < uvs_pkg::cmp_t'(sector_count));
    last_stack = (uvs_pkg::cmp_t'(st) + uvs_pkg::cmp_t'(1)) == uvs_pkg::cmp_t'(stack_count);
    side_d.tex_s = (|pts[uvs_pkg::IDX_W+15:16]) ? 16'hFFFF : pts[15:0];
    side_d.tex_t = (|ptt[uvs_pkg::IDX_W+15:16]) ? 16'hFFFF : ptt[15:0];
    side_d.k1    = pk[15:0];
    side_d.k2    = pk[15:0] + 16'(sc_p1);
    side_d.upper = in_mesh && (st != '0);
    side_d.lower = in_mesh && !last_stack;
  end

  logic [15:0]    u1, v1_ph;
  uvs_pkg::side_t side1, side2, side3, side4, side5;

  always_ff @(posedge clk) begin
    if (en1) begin
      u1    <= u_d;
      v1_ph <= v_d;
      side1 <= side_d;
    end
    if (en2) side2 <= side1;
    if (en3) side3 <= side2;
    if (en4) side4 <= side3;
    if (en5) side5 <= side4;
  end

  // stage 2: sine table
  uvs_pkg::trig_t trig2;

  uvs_sincos u_sincos (
    .clk  (clk),
    .en   (en2),
    .u    (u1),
    .v    (v1_ph),
    .trig (trig2)
  );

  // stage 3: trig products
  logic signed [16:0] rad_s;
  logic signed [31:0] px3, py3;
  logic signed [32:0] rsu3;
  logic signed [15:0] nz3;

  assign rad_s = $signed({1'b0, radius});

  always_ff @(posedge clk) begin
    if (en3) begin
      px3  <= trig2.cu * trig2.cv;
      py3  <= trig2.cu * trig2.sv;
      rsu3 <= rad_s * trig2.su;
      nz3  <= trig2.su;
    end
  end

  // stage 4: radius products, normal and z rounding
  logic signed [48:0] rpx4, rpy4;
  logic [15:0]        nx4, ny4, nz4, pz4;

  always_ff @(posedge clk) begin
    if (en4) begin
      rpx4 <= rad_s * px3;
      rpy4 <= rad_s * py3;
      nx4  <= uvs_pkg::rnd_sat(50'(px3), 15);
      ny4  <= uvs_pkg::rnd_sat(50'(py3), 15);
      pz4  <= uvs_pkg::rnd_sat(50'(rsu3), 15);
      nz4  <= nz3;
    end
  end

  // stage 5: output register
  logic [15:0] px5, py5, pz5, nx5, ny5, nz5;

  always_ff @(posedge clk) begin
    if (en5) begin
      px5 <= uvs_pkg::rnd_sat(50'(rpx4), 30);
      py5 <= uvs_pkg::rnd_sat(50'(rpy4), 30);
      pz5 <= pz4;
      nx5 <= nx4;
      ny5 <= ny4;
      nz5 <= nz4;
    end
  end

  assign vtx_rsp.valid           = v5;
  assign vtx_rsp.pos_x           = px5;
  assign vtx_rsp.pos_y           = py5;
  assign vtx_rsp.pos_z           = pz5;
  assign vtx_rsp.norm_x          = nx5;
  assign vtx_rsp.norm_y          = ny5;
  assign vtx_rsp.norm_z          = nz5;
  assign vtx_rsp.tex_s           = side5.tex_s;
  assign vtx_rsp.tex_t           = side5.tex_t;
  assign vtx_rsp.row_base        = side5.k1;
  assign vtx_rsp.next_row_base   = side5.k2;
  assign vtx_rsp.upper_tri_valid = side5.upper;
  assign vtx_rsp.lower_tri_valid = side5.lower;

endmodule

`default_nettype wire

// ===== src/uvs_sincos.sv =====
// ----------------------------------------------------------------------------
// uvs_sincos
// Table stage: sine and cosine of both phase angles, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_sincos (
  input  logic           clk,
  input  logic           en,
  input  logic [15:0]    u,
  input  logic [15:0]    v,
  output uvs_pkg::trig_t trig
);

  always_ff @(posedge clk) begin
    if (en) begin
      trig.cu <= uvs_pkg::cos_of(u);
      trig.su <= uvs_pkg::sin_of(u);
      trig.cv <= uvs_pkg::cos_of(v);
      trig.sv <= uvs_pkg::sin_of(v);
    end
  end

endmodule

`default_nettype wire

// ===== src/uvs_checker.sv =====
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks on the UV sphere generator: response hold, occupancy
// and quiet after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uv_sphere_vertex_and_index_generator_top_macros.svh"

module uvs_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready
);

  logic       acc_in, acc_out;
  logic [3:0] inflight;

  assign acc_in  = req_valid && req_ready;
  assign acc_out = rsp_valid && rsp_ready;

  // count beats taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 4'd0;
    end else begin
      inflight <= inflight + {3'd0, acc_in} - {3'd0, acc_out};
    end
  end

  `UVS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
  `UVS_ASSERT_IMP(a_rsp_has_src, rsp_valid, inflight != 4'd0)
  `UVS_ASSERT_IMP(a_capacity, 1'b1, inflight <= 4'd5)
  `UVS_ASSERT_IMP(a_quiet_after_rst, $past(rst), !rsp_valid)

endmodule

bind uv_sphere_vertex_and_index_generator_top uvs_checker u_uvs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (vtx_req.valid),
  .req_ready (vtx_req.ready),
  .rsp_valid (vtx_rsp.valid),
  .rsp_ready (vtx_rsp.ready)
);

`default_nettype wire

// ===== tb/tb_uv_sphere_vertex_and_index_generator_top.sv =====
// ----------------------------------------------------------------------------
// tb_uv_sphere_vertex_and_index_generator_top
// Drives grid points into the UV sphere generator under several mesh settings
// and compares every vertex beat field by field with a built-in vertex
// predictor (sine table, trig products, rounding, saturation, triangle bases).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uv_sphere_vertex_and_index_generator_top;

  localparam int          TRIG_DEPTH  = uvs_pkg::SINE_DEPTH;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] UNIT_Q30    = 64'd1073741824;
  localparam logic [15:0] QUARTER     = 16'd16384;
  localparam int          DRAIN_SLACK = 12;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
    logic [15:0] tex_s;
    logic [15:0] tex_t;
    logic [15:0] row_base;
    logic [15:0] next_row_base;
    logic        upper;
    logic        lower;
  } vertex_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [uvs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [uvs_pkg::CFG_DATA_W-1:0] cfg_data;

  uvs_req_if req_ch();
  uvs_rsp_if rsp_ch();

  uv_sphere_vertex_and_index_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .vtx_req   (req_ch),
    .vtx_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mesh settings as the block should hold them
  logic [7:0]  mesh_sectors;
  logic [7:0]  mesh_stacks;
  logic [15:0] mesh_radius;
  logic [15:0] lon_step;
  logic [15:0] lat_step;
  logic [15:0] s_step;
  logic [15:0] t_step;

  vertex_t     pending_vertices[$];
  int          fail_count;
  int unsigned burst_left;
  bit          bursty;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_uv_sphere_vertex_and_index_generator_top: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // sin(a * pi/2 / 2^30) in Q30 by a truncated Taylor series
  function automatic logic [63:0] quarter_wave(input logic [63:0] a);
    logic [63:0] x, x2, acc, term;
    int n;
    x    = (a * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    acc  = x;
    term = x;
    for (n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    if (acc > UNIT_Q30) acc = UNIT_Q30;
    return acc;
  endfunction

  function automatic logic signed [15:0] table_sine(input int unsigned k);
    logic [63:0] frac, r, s;
    logic [1:0]  quad;
    k    = k % TRIG_DEPTH;
    frac = (64'(k) << 32) / 64'(TRIG_DEPTH);
    quad = frac[31:30];
    r    = frac & (UNIT_Q30 - 64'd1);
    if (quad[0]) r = UNIT_Q30 - r;
    s = (quarter_wave(r) + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return quad[1] ? -$signed(s[15:0]) : $signed(s[15:0]);
  endfunction

  function automatic logic signed [15:0] phase_sine(input logic [15:0] ph);
    return table_sine(int'((64'(ph) * 64'(TRIG_DEPTH)) >> 16));
  endfunction

  // round half up by 2^sh
  function automatic longint shift_round(input longint p, input int sh);
    return (p + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic [15:0] clamp_s16(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] clamp_u16(input longint unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic vertex_t vertex_of(input logic [7:0] stack, input logic [7:0] sector);
    vertex_t     vx;
    logic [15:0] u, v;
    longint      cu, su, cv, sv, px, py, r;
    int unsigned k1, k2;
    bit          in_mesh;
    u  = QUARTER - 16'(16'(stack) * lat_step);
    v  = 16'(16'(sector) * lon_step);
    cu = phase_sine(u + QUARTER);
    su = phase_sine(u);
    cv = phase_sine(v + QUARTER);
    sv = phase_sine(v);
    px = cu * cv;
    py = cu * sv;
    r  = longint'(mesh_radius);
    vx.pos_x  = clamp_s16(shift_round(r * px, 30));
    vx.pos_y  = clamp_s16(shift_round(r * py, 30));
    vx.pos_z  = clamp_s16(shift_round(r * su, 15));
    vx.norm_x = clamp_s16(shift_round(px, 15));
    vx.norm_y = clamp_s16(shift_round(py, 15));
    vx.norm_z = clamp_s16(su);
    vx.tex_s  = clamp_u16(longint'(sector) * longint'(s_step));
    vx.tex_t  = clamp_u16(longint'(stack) * longint'(t_step));
    k1 = int'(stack) * (int'(mesh_sectors) + 1) + int'(sector);
    k2 = k1 + int'(mesh_sectors) + 1;
    vx.row_base      = k1[15:0];
    vx.next_row_base = k2[15:0];
    in_mesh  = (stack < mesh_stacks) && (sector < mesh_sectors);
    vx.upper = in_mesh && (stack != 8'd0);
    vx.lower = in_mesh && (int'(stack) != int'(mesh_stacks) - 1);
    return vx;
  endfunction

  // ------------------------------------------------------------------ checker

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got, input bit is_signed);
    int w, g;
    if (want !== got) begin
      w = is_signed ? int'($signed(want)) : int'(want);
      g = is_signed ? int'($signed(got)) : int'(got);
      $error("%s mismatch: expected %0d (0x%04h), got %0d (0x%04h)", name, w, want, g, got);
      fail_count++;
    end
  endfunction

  initial begin
    vertex_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        if (pending_vertices.size() == 0) begin
          $error("vertex beat with nothing pending: row_base %0d", rsp_ch.row_base);
          fail_count++;
        end else begin
          want = pending_vertices.pop_front();
          check_field("pos_x", want.pos_x, rsp_ch.pos_x, 1'b1);
          check_field("pos_y", want.pos_y, rsp_ch.pos_y, 1'b1);
          check_field("pos_z", want.pos_z, rsp_ch.pos_z, 1'b1);
          check_field("norm_x", want.norm_x, rsp_ch.norm_x, 1'b1);
          check_field("norm_y", want.norm_y, rsp_ch.norm_y, 1'b1);
          check_field("norm_z", want.norm_z, rsp_ch.norm_z, 1'b1);
          check_field("tex_s", want.tex_s, rsp_ch.tex_s, 1'b0);
          check_field("tex_t", want.tex_t, rsp_ch.tex_t, 1'b0);
          check_field("row_base", want.row_base, rsp_ch.row_base, 1'b0);
          check_field("next_row_base", want.next_row_base, rsp_ch.next_row_base, 1'b0);
          check_field("upper_tri_valid", 16'(want.upper), 16'(rsp_ch.upper_tri_valid),
                      1'b0);
          check_field("lower_tri_valid", 16'(want.lower), 16'(rsp_ch.lower_tri_valid),
                      1'b0);
        end
      end
    end
  end

  // receiver: switch between always ready, light and heavy random stalls,
  // and occasional long stalls
  initial begin
    int unsigned mode, tick, hold;
    rsp_ch.ready <= 1'b0;
    mode = 0;
    tick = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (tick == 0) begin
        mode = $urandom_range(0, 3);
        tick = $urandom_range(20, 80);
      end
      tick--;
      case (mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (hold != 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
          end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) hold = $urandom_range(1, 15);
          end
        end
      endcase
    end
  end

  // ----------------------------------------------------------------- drivers

  task automatic send_point(input logic [7:0] stack, input logic [7:0] sector);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = bursty ? $urandom_range(0, 7) : 0;
      repeat (gap) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.stack_index  <= stack;
    req_ch.sector_index <= sector;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_vertices = {pending_vertices, vertex_of(stack, sector)};
  endtask

  // drop valid and wait until every vertex has come back
  task automatic settle_pipeline();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input uvs_pkg::cfg_reg_t which, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    case (which)
      uvs_pkg::REG_SECTOR_COUNT:      mesh_sectors = value[7:0];
      uvs_pkg::REG_STACK_COUNT:       mesh_stacks  = value[7:0];
      uvs_pkg::REG_RADIUS:            mesh_radius  = value;
      uvs_pkg::REG_SECTOR_PHASE_STEP: lon_step     = value;
      uvs_pkg::REG_STACK_PHASE_STEP:  lat_step     = value;
      uvs_pkg::REG_TEX_S_STEP:        s_step       = value;
      uvs_pkg::REG_TEX_T_STEP:        t_step       = value;
      default: ;
    endcase
  endtask

  task automatic program_mesh(input logic [7:0] sectors, input logic [7:0] stacks,
                              input logic [15:0] rad, input logic [15:0] lon,
                              input logic [15:0] lat, input logic [15:0] ts,
                              input logic [15:0] tt);
    settle_pipeline();
    write_reg(uvs_pkg::REG_SECTOR_COUNT, {8'd0, sectors});
    write_reg(uvs_pkg::REG_STACK_COUNT, {8'd0, stacks});
    write_reg(uvs_pkg::REG_RADIUS, rad);
    write_reg(uvs_pkg::REG_SECTOR_PHASE_STEP, lon);
    write_reg(uvs_pkg::REG_STACK_PHASE_STEP, lat);
    write_reg(uvs_pkg::REG_TEX_S_STEP, ts);
    write_reg(uvs_pkg::REG_TEX_T_STEP, tt);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ------------------------------------------------------------------- tests

  // default mesh: poles, last row and column, one past the last, index extremes
  task automatic test_reset_mesh();
    bursty = 1'b0;
    send_point(8'd0, 8'd0);
    send_point(8'd1, 8'd1);
    send_point(8'd9, 8'd18);
    send_point(8'd17, 8'd35);
    send_point(8'd17, 8'd0);
    send_point(8'd18, 8'd36);
    send_point(8'd16, 8'd36);
    send_point(8'd0, 8'd255);
    send_point(8'd255, 8'd0);
    send_point(8'd255, 8'd255);
  endtask

  // largest and smallest register values: saturation, index wrap, zero radius
  task automatic test_register_extremes();
    bursty = 1'b0;
    program_mesh(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'd32768, 16'hFFFF, 16'hFFFF);
    send_point(8'd254, 8'd254);
    send_point(8'd255, 8'd255);
    send_point(8'd0, 8'd0);
    send_point(8'd128, 8'd64);
    program_mesh(8'd3, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_point(8'd0, 8'd0);
    send_point(8'd1, 8'd2);
    send_point(8'd1, 8'd3);
    send_point(8'd2, 8'd0);
  endtask

  // counts below the legal range and a latitude step past a half turn
  task automatic test_degenerate_counts();
    bursty = 1'b0;
    program_mesh(8'd0, 8'd0, 16'hFFFF, 16'd300, 16'd40000, 16'hFFFF, 16'd1);
    send_point(8'd0, 8'd0);
    send_point(8'd3, 8'd5);
    send_point(8'd255, 8'd255);
    program_mesh(8'd1, 8'd1, 16'd256, 16'd21845, 16'd16384, 16'd40960, 16'd40960);
    send_point(8'd0, 8'd0);
    send_point(8'd0, 8'd1);
  endtask

  task automatic random_mesh();
    logic [7:0]  sectors, stacks;
    logic [15:0] rad, lon, lat, ts, tt;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: sectors = 8'($urandom_range(3, 16));
      5, 6, 7:       sectors = 8'($urandom_range(17, 64));
      default:       sectors = 8'($urandom_range(65, 255));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: stacks = 8'($urandom_range(2, 16));
      5, 6, 7:       stacks = 8'($urandom_range(17, 64));
      default:       stacks = 8'($urandom_range(65, 255));
    endcase
    rad = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535))
                                      : 16'($urandom_range(128, 2048));
    lon = ($urandom_range(0, 3) != 0) ? 16'(65536 / int'(sectors)) : 16'($urandom);
    lat = ($urandom_range(0, 3) != 0) ? 16'(32768 / int'(stacks))
                                      : 16'($urandom_range(0, 32768));
    ts  = ($urandom_range(0, 3) != 0) ? 16'(40960 / int'(sectors)) : 16'($urandom);
    tt  = ($urandom_range(0, 3) != 0) ? 16'(40960 / int'(stacks)) : 16'($urandom);
    program_mesh(sectors, stacks, rad, lon, lat, ts, tt);
  endtask

  // mostly points on or just past the mesh, weighted toward the pole rows,
  // plus fully random indices
  task automatic test_random_meshes();
    int          phase;
    int unsigned kind;
    logic [7:0]  stack, sector;
    for (phase = 0; phase < 7; phase++) begin
      random_mesh();
      bursty = (phase % 3 != 0);
      repeat (250) begin
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
          stack  = 8'($urandom_range(0, int'(mesh_stacks)));
          sector = 8'($urandom_range(0, int'(mesh_sectors)));
        end else if (kind < 75) begin
          case ($urandom_range(0, 2))
            0:       stack = 8'd0;
            1:       stack = mesh_stacks - 8'd1;
            default: stack = mesh_stacks;
          endcase
          sector = 8'($urandom_range(0, int'(mesh_sectors)));
        end else begin
          stack  = 8'($urandom_range(0, 255));
          sector = 8'($urandom_range(0, 255));
        end
        send_point(stack, sector);
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= uvs_pkg::REG_SECTOR_COUNT;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.stack_index  <= '0;
    req_ch.sector_index <= '0;
    mesh_sectors = uvs_pkg::SECTOR_COUNT_RST;
    mesh_stacks  = uvs_pkg::STACK_COUNT_RST;
    mesh_radius  = uvs_pkg::RADIUS_RST;
    lon_step     = uvs_pkg::SECTOR_PHASE_STEP_RST;
    lat_step     = uvs_pkg::STACK_PHASE_STEP_RST;
    s_step       = uvs_pkg::TEX_S_STEP_RST;
    t_step       = uvs_pkg::TEX_T_STEP_RST;
    fail_count   = 0;
    burst_left   = 0;
    bursty       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_mesh();
    test_register_extremes();
    test_degenerate_counts();
    test_random_meshes();
    settle_pipeline();

    if (fail_count == 0 && pending_vertices.size() == 0) begin
      $display("tb_uv_sphere_vertex_and_index_generator_top: done, clean");
    end else begin
      $display("tb_uv_sphere_vertex_and_index_generator_top: done, errors");
    end
    $finish;
  end

endmodule
